@@ rtl/pixel_color_math_brightness_assert.svh @@
// Assertion macros for the pixel color math and brightness block, used
// by the checker; all need clk in scope, all but PCMB_ASSERT_RESET arst_n.
`ifndef PIXEL_COLOR_MATH_BRIGHTNESS_ASSERT_SVH
`define PIXEL_COLOR_MATH_BRIGHTNESS_ASSERT_SVH

// condition must hold at every edge out of reset
`define PCMB_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// antecedent implies consequent in the same cycle, out of reset
`define PCMB_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// checked also while reset is asserted
`define PCMB_ASSERT_RESET(label, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/pcmb_pkg.sv @@
// Shared types and constants of the pixel color math and brightness block.
// No dependencies; imported by every module of the block.
package pcmb_pkg;

	localparam int CH_W       = 5;
	localparam int NUM_CH     = 3;
	localparam int COLOR_W    = CH_W * NUM_CH;
	localparam int SRC_W      = 3;
	localparam int MASK_W     = 6;
	localparam int BRIGHT_W   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	// source code of the backdrop / fixed color layer
	localparam logic [SRC_W-1:0] SRC_BACKDROP = 3'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SUBTRACT  = 3'd0,
		CFG_USE_SUB   = 3'd1,
		CFG_HALVE     = 3'd2,
		CFG_MATH_MASK = 3'd3,
		CFG_FIXED     = 3'd4,
		CFG_BRIGHT    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic                subtract_mode;
		logic                use_sub_screen;
		logic                halve_enable;
		logic [MASK_W-1:0]   math_enable_mask;
		logic [COLOR_W-1:0]  fixed_color;
		logic [BRIGHT_W-1:0] brightness;
	} cfg_t;

endpackage

@@ rtl/pcmb_mix.sv @@
// Color math for one pixel: window gating, sub pixel select, per-channel
// clamped add / subtract with optional halving. Depends on pcmb_pkg.
module pcmb_mix import pcmb_pkg::*; (
	input  cfg_t               cfg,
	input  logic [COLOR_W-1:0] main_color,
	input  logic [SRC_W-1:0]   main_source,
	input  logic [COLOR_W-1:0] sub_color,
	input  logic [SRC_W-1:0]   sub_source,
	input  logic               main_window_pass,
	input  logic               sub_window_pass,
	output logic [COLOR_W-1:0] pix
);

	logic [COLOR_W-1:0] main_m;
	logic [COLOR_W-1:0] sub_c;
	logic [COLOR_W-1:0] mixed;
	logic [7:0]         mask_ext;
	logic               enabled;
	logic               halve;

	assign main_m   = main_window_pass ? main_color : '0;
	assign sub_c    = cfg.use_sub_screen ? sub_color : cfg.fixed_color;
	// sources 6 and 7 have no mask bit
	assign mask_ext = {2'b00, cfg.math_enable_mask};
	assign enabled  = mask_ext[main_source];
	assign halve    = cfg.halve_enable && main_window_pass &&
			(!cfg.use_sub_screen || sub_source != SRC_BACKDROP);

	for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
		logic [CH_W-1:0] a;
		logic [CH_W-1:0] b;
		logic [CH_W:0]   sum;
		logic [CH_W-1:0] diff;
		logic [CH_W:0]   raw;

		assign a    = main_m[i*CH_W +: CH_W];
		assign b    = sub_c[i*CH_W +: CH_W];
		assign sum  = {1'b0, a} + {1'b0, b};
		assign diff = (a > b) ? (a - b) : '0;
		assign raw  = cfg.subtract_mode ? {1'b0, diff} : sum;

		assign mixed[i*CH_W +: CH_W] = halve ? raw[CH_W:1] :
				(raw[CH_W] ? '1 : raw[CH_W-1:0]);
	end

	always_comb begin
		if (!main_window_pass && !sub_window_pass) begin
			pix = '0;
		end else if (enabled && sub_window_pass) begin
			pix = mixed;
		end else begin
			pix = main_m;
		end
	end

endmodule

@@ rtl/pcmb_bright.sv @@
// Brightness scaling and red/blue swap of one 15-bit pixel.
// Per channel round(level*c/15) via a reciprocal; depends on pcmb_pkg.
module pcmb_bright import pcmb_pkg::*; (
	input  logic [BRIGHT_W-1:0] level,
	input  logic [COLOR_W-1:0]  color,
	output logic [COLOR_W-1:0]  pixel
);

	localparam int P_W    = BRIGHT_W + CH_W;
	localparam int RECIP_SH = 15;
	localparam int PROD_W = P_W + 12;

	for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
		logic [P_W-1:0]    p;
		logic [P_W-1:0]    y;
		logic [PROD_W-1:0] prod;

		// (2*l*c + 15) / 30 == (l*c + 7) / 15
		assign p = P_W'(level) * P_W'(color[i*CH_W +: CH_W]);
		assign y = p + P_W'(7);
		// y * 2185 / 32768 stands in for y / 15 over the whole range of y
		assign prod = (PROD_W'(y) << 11) + (PROD_W'(y) << 7) + (PROD_W'(y) << 3)
				+ PROD_W'(y);
		// channel order reverses on output
		assign pixel[(NUM_CH-1-i)*CH_W +: CH_W] = prod[RECIP_SH +: CH_W];
	end

endmodule

@@ rtl/pixel_color_math_brightness.sv @@
// Top level of the pixel color math and brightness block.
// Holds the config registers and both pipeline stages; uses pcmb_pkg,
// pcmb_mix and pcmb_bright.
//
//  channel   handshake          payload
//  -------   ----------------   ------------------------------------------
//  input     start / busy       main_color main_source sub_color sub_source
//                               main_window_pass sub_window_pass
//  result    done (strobe)      pixel_out
//  config    cfg_we             cfg_index cfg_data
//
// One pixel per cycle while busy is low. A taken pixel goes through the input
// register, then color math and brightness scaling into the result register,
// which drives pixel_out and done. busy is high during reset and until rdy_q
// is set after reset release, low otherwise.
// The receiver cannot stall; a result is valid for its single done cycle.
module pixel_color_math_brightness import pcmb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [COLOR_W-1:0]    main_color,
	input  logic [SRC_W-1:0]      main_source,
	input  logic [COLOR_W-1:0]    sub_color,
	input  logic [SRC_W-1:0]      sub_source,
	input  logic                  main_window_pass,
	input  logic                  sub_window_pass,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [COLOR_W-1:0]    pixel_out
);

	cfg_t               cfg_q;
	logic               rdy_q;
	logic               valid_s1;
	logic [COLOR_W-1:0] main_color_s1;
	logic [SRC_W-1:0]   main_source_s1;
	logic [COLOR_W-1:0] sub_color_s1;
	logic [SRC_W-1:0]   sub_source_s1;
	logic               mwin_s1;
	logic               swin_s1;
	logic               done_s2;
	logic [COLOR_W-1:0] pixel_s2;
	logic [COLOR_W-1:0] mix_pix;
	logic [COLOR_W-1:0] scaled;
	logic               take;

	assign busy = !rdy_q;
	assign take = start && rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SUBTRACT:  cfg_q.subtract_mode    <= cfg_data[0];
				CFG_USE_SUB:   cfg_q.use_sub_screen   <= cfg_data[0];
				CFG_HALVE:     cfg_q.halve_enable     <= cfg_data[0];
				CFG_MATH_MASK: cfg_q.math_enable_mask <= cfg_data[MASK_W-1:0];
				CFG_FIXED:     cfg_q.fixed_color      <= cfg_data[COLOR_W-1:0];
				CFG_BRIGHT:    cfg_q.brightness       <= cfg_data[BRIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q    <= 1'b0;
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			rdy_q    <= 1'b1;
			valid_s1 <= take;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			main_color_s1  <= main_color;
			main_source_s1 <= main_source;
			sub_color_s1   <= sub_color;
			sub_source_s1  <= sub_source;
			mwin_s1        <= main_window_pass;
			swin_s1        <= sub_window_pass;
		end
		if (valid_s1) begin
			pixel_s2 <= scaled;
		end
	end

	pcmb_mix u_mix (
		.cfg              (cfg_q),
		.main_color       (main_color_s1),
		.main_source      (main_source_s1),
		.sub_color        (sub_color_s1),
		.sub_source       (sub_source_s1),
		.main_window_pass (mwin_s1),
		.sub_window_pass  (swin_s1),
		.pix              (mix_pix)
	);

	pcmb_bright u_bright (
		.level (cfg_q.brightness),
		.color (mix_pix),
		.pixel (scaled)
	);

	assign done      = done_s2;
	assign pixel_out = pixel_s2;

endmodule

@@ rtl/pcmb_checker.sv @@
// Port-level checker for the pixel color math and brightness block, bound
// to the top level. Depends on pcmb_pkg and the assertion macro header.
`include "pixel_color_math_brightness_assert.svh"

module pcmb_checker import pcmb_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  done,
	input logic [COLOR_W-1:0]    pixel_out
);

	logic [BRIGHT_W-1:0] bright_q;

	// shadow of the brightness register, seen only through the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= '0;
		end else if (cfg_we && cfg_index == CFG_BRIGHT) begin
			bright_q <= cfg_data[BRIGHT_W-1:0];
		end
	end

	// every transfer in gives exactly one result, through the input and result registers
	`PCMB_ASSERT_ALWAYS(a_latency, done == ($past(start && !busy, 2) && $past(arst_n, 1)), "result strobe does not match accepted pixels")
	// zero brightness blanks every pixel
	`PCMB_ASSERT_IMPL(a_black, done && bright_q == '0, pixel_out == '0, "nonzero pixel at zero brightness")
	// nothing accepted or put out while reset is asserted
	`PCMB_ASSERT_RESET(a_reset, !arst_n, busy && !done, "busy low or result out during reset")

endmodule

bind pixel_color_math_brightness pcmb_checker u_pcmb_checker (.*);
